@@ hw/rtl/modular_scalar_multiply_core_defines.svh @@
// assertion macros shared by the modular scalar multiply rtl
// no dependencies; expects clk and rst in the scope of each use
`ifndef MODULAR_SCALAR_MULTIPLY_CORE_DEFINES_SVH
`define MODULAR_SCALAR_MULTIPLY_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MSM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define MSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MSM_ASSERT_IMPL(lbl, ante, cons)
`define MSM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/msm_pkg.sv @@
// widths, register indexes and stage types for the modular scalar multiplier
// no dependencies
package msm_pkg;
  localparam int W     = 49;
  localparam int IDX_W = 2;

  localparam logic [IDX_W-1:0] CFG_MODULUS    = 2'd0;
  localparam logic [IDX_W-1:0] CFG_MULTIPLIER = 2'd1;

  // reduction stage: coefficient bits are folded into r msb first
  typedef struct packed {
    logic         valid;
    logic [W-1:0] a;
    logic [W-1:0] r;
  } red_t;

  // multiply stage: double-and-add of the reduced operand x
  typedef struct packed {
    logic         valid;
    logic [W-1:0] x;
    logic [W-1:0] r;
  } mul_t;
endpackage

@@ hw/rtl/msm_if.sv @@
// valid/ready channels for coefficients and reduced products
// depends on msm_pkg
interface msm_coef_if;
  logic                  valid;
  logic                  ready;
  logic [msm_pkg::W-1:0] coefficient;
  modport source (output valid, output coefficient, input ready);
  modport sink (input valid, input coefficient, output ready);
endinterface

interface msm_prod_if;
  logic                  valid;
  logic                  ready;
  logic [msm_pkg::W-1:0] product_mod_q;
  modport source (output valid, output product_mod_q, input ready);
  modport sink (input valid, input product_mod_q, output ready);
endinterface

@@ hw/rtl/msm_reduce_stage.sv @@
// one step of coefficient mod modulus: r = (2r + bit) mod m
// depends on msm_pkg
module msm_reduce_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic [msm_pkg::W-1:0] modulus,
  input  logic                  in_bit,
  input  msm_pkg::red_t         d,
  output msm_pkg::red_t         q
);
  logic [msm_pkg::W:0] t;
  logic [msm_pkg::W:0] t_red;

  always_comb begin
    t     = {d.r, in_bit};
    t_red = (t >= {1'b0, modulus}) ? t - {1'b0, modulus} : t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q.valid <= d.valid;
    end
    if (adv) begin
      q.a <= d.a;
      q.r <= t_red[msm_pkg::W-1:0];
    end
  end
endmodule

@@ hw/rtl/msm_mul_stage.sv @@
// one double-and-add step: r = 2r mod m, then r = (r + x) mod m if the bit is set
// depends on msm_pkg
module msm_mul_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic [msm_pkg::W-1:0] modulus,
  input  logic                  b_bit,
  input  msm_pkg::mul_t         d,
  output msm_pkg::mul_t         q
);
  logic [msm_pkg::W:0] m_ext;
  logic [msm_pkg::W:0] dbl;
  logic [msm_pkg::W:0] dbl_red;
  logic [msm_pkg::W:0] sum;
  logic [msm_pkg::W:0] r_next;

  always_comb begin
    m_ext   = {1'b0, modulus};
    dbl     = {d.r, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum     = dbl_red + {1'b0, d.x};
    if (b_bit) begin
      r_next = (sum >= m_ext) ? sum - m_ext : sum;
    end else begin
      r_next = dbl_red;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (adv) begin
      q.valid <= d.valid;
    end
    if (adv) begin
      q.x <= d.x;
      q.r <= r_next[msm_pkg::W-1:0];
    end
  end
endmodule

@@ hw/rtl/modular_scalar_multiply_core.sv @@
// Each coefficient gives product_mod_q = (coefficient * multiplier) mod modulus,
// with 0 when modulus is zero. One item is accepted every cycle while the output
// is not stalled. Each item passes through W stages that reduce the coefficient
// one bit at a time and then W double-and-add stages, one multiplier bit each.
// A stalled output holds the whole pipeline. The user must write registers only
// while no item is in flight; the block itself does not enforce this.
// top level; depends on msm_pkg, msm_if, msm_reduce_stage, msm_mul_stage and the defines header
`include "modular_scalar_multiply_core_defines.svh"

module modular_scalar_multiply_core (
  input  logic                      clk,
  input  logic                      rst,
  msm_coef_if.sink                  coef_in,
  msm_prod_if.source                prod_out,
  input  logic                      cfg_we,
  input  logic [msm_pkg::IDX_W-1:0] cfg_index,
  input  logic [msm_pkg::W-1:0]     cfg_data
);
  logic [msm_pkg::W-1:0] modulus;
  logic [msm_pkg::W-1:0] multiplier;
  logic                  adv;

  msm_pkg::red_t red [0:msm_pkg::W];
  msm_pkg::mul_t mul [0:msm_pkg::W];

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus    <= '1;
      multiplier <= msm_pkg::W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        msm_pkg::CFG_MODULUS:    modulus    <= cfg_data;
        msm_pkg::CFG_MULTIPLIER: multiplier <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv           = !mul[msm_pkg::W].valid || prod_out.ready;
  assign coef_in.ready = adv;

  always_comb begin
    red[0].valid = coef_in.valid;
    red[0].a     = coef_in.coefficient;
    red[0].r     = '0;
    mul[0].valid = red[msm_pkg::W].valid;
    mul[0].x     = red[msm_pkg::W].r;
    mul[0].r     = '0;
  end

  for (genvar g = 0; g < msm_pkg::W; g++) begin : g_stage
    msm_reduce_stage u_red (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .modulus (modulus),
      .in_bit  (red[g].a[msm_pkg::W-1-g]),
      .d       (red[g]),
      .q       (red[g+1])
    );
    msm_mul_stage u_mul (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .modulus (modulus),
      .b_bit   (multiplier[msm_pkg::W-1-g]),
      .d       (mul[g]),
      .q       (mul[g+1])
    );
  end

  assign prod_out.valid         = mul[msm_pkg::W].valid;
  assign prod_out.product_mod_q = (modulus == '0) ? '0 : mul[msm_pkg::W].r;

  // results are fully reduced
  `MSM_ASSERT_IMPL(a_reduced, prod_out.valid && modulus != '0, prod_out.product_mod_q < modulus)
  `MSM_ASSERT_IMPL(a_zero_mod, prod_out.valid && modulus == '0, prod_out.product_mod_q == '0)
  // back pressure only comes from a waiting result
  `MSM_ASSERT_IMPL(a_stall_src, !coef_in.ready, prod_out.valid && !prod_out.ready)
  // a waiting result is never dropped
  `MSM_ASSERT_NEXT(a_hold, prod_out.valid && !prod_out.ready, prod_out.valid)
endmodule

@@ sim/tb_top.sv @@
// self-checking bench for modular_scalar_multiply_core: streams coefficients through
// several modulus/multiplier settings and checks every product against a local model
// depends on msm_pkg, msm_if and the core rtl
`timescale 1ns / 1ps

module tb_top;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [msm_pkg::IDX_W-1:0] cfg_index;
  logic [msm_pkg::W-1:0] cfg_data;

  msm_coef_if coef_ch ();
  msm_prod_if prod_ch ();

  modular_scalar_multiply_core u_top (
    .clk      (clk),
    .rst      (rst),
    .coef_in  (coef_ch),
    .prod_out (prod_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  localparam logic [msm_pkg::W-1:0] ALL_ONES = {msm_pkg::W{1'b1}};
  localparam logic [msm_pkg::IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [msm_pkg::IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  logic [msm_pkg::W-1:0] coef_pending[$];
  logic [msm_pkg::W-1:0] product_expected[$];
  logic [msm_pkg::W-1:0] cur_modulus;
  logic [msm_pkg::W-1:0] cur_multiplier;
  int tx_idle_pct;
  int rx_idle_pct;
  int n_errors = 0;
  int hold_cnt;
  bit hold_done;
  bit hold_req = 1'b0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic [msm_pkg::W-1:0] mod_product(logic [msm_pkg::W-1:0] coef,
                                                        logic [msm_pkg::W-1:0] mult,
                                                        logic [msm_pkg::W-1:0] q);
    logic [2*msm_pkg::W-1:0] p;
    if (q == '0) return '0;
    p = coef;
    p = p * mult;
    return msm_pkg::W'(p % q);
  endfunction

  function automatic logic [msm_pkg::W-1:0] rand_word();
    return msm_pkg::W'({$urandom, $urandom});
  endfunction

  // driver: offers the head of the pending queue, holds it until taken
  always @(posedge clk) begin
    if (rst) begin
      coef_ch.valid <= 1'b0;
    end else if (!(coef_ch.valid && !coef_ch.ready)) begin
      if (coef_ch.valid && coef_ch.ready) begin
        product_expected.push_back(mod_product(coef_ch.coefficient, cur_multiplier,
                                               cur_modulus));
        void'(coef_pending.pop_front());
      end
      if (coef_pending.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        coef_ch.valid <= 1'b1;
        coef_ch.coefficient <= coef_pending[0];
      end else begin
        coef_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off so the pipe backs up
  always @(posedge clk) begin
    if (rst) begin
      prod_ch.ready <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_cnt > 0) begin
      prod_ch.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && hold_req) begin
      prod_ch.ready <= 1'b0;
      hold_cnt <= 400;
      hold_done <= 1'b1;
    end else begin
      prod_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [msm_pkg::W-1:0] exp_prod;
    if (!rst && prod_ch.valid && prod_ch.ready) begin
      if (product_expected.size() == 0) begin
        $error("unexpected item: product_mod_q actual %0d", prod_ch.product_mod_q);
        n_errors++;
      end else begin
        exp_prod = product_expected.pop_front();
        if (prod_ch.product_mod_q !== exp_prod) begin
          $error("product_mod_q mismatch: expected %0d actual %0d", exp_prod,
                 prod_ch.product_mod_q);
          n_errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (coef_pending.size() > 0 || coef_ch.valid || product_expected.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [msm_pkg::IDX_W-1:0] idx, logic [msm_pkg::W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == msm_pkg::CFG_MODULUS) cur_modulus = val;
    else if (idx == msm_pkg::CFG_MULTIPLIER) cur_multiplier = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_random(int n);
    logic [msm_pkg::W-1:0] c;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: c = rand_word();
        1: c = (cur_modulus == '0) ? '0 : cur_modulus - 1;
        2: c = '0;
        3: c = ALL_ONES;
        default: c = (cur_modulus == '0) ? rand_word() : rand_word() % cur_modulus;
      endcase
      coef_pending.push_back(c);
    end
  endtask

  initial begin
    logic [msm_pkg::W-1:0] q;
    tx_idle_pct = 29;
    rx_idle_pct = 29;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cur_modulus = ALL_ONES;
    cur_multiplier = 1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset values: identity multiply modulo all ones
    coef_pending.push_back('0);
    coef_pending.push_back(ALL_ONES);
    coef_pending.push_back(ALL_ONES - 1);
    coef_pending.push_back(49'h0AAAA_AAAA_AAAA);
    coef_pending.push_back(49'h15555_5555_5555);
    wait_drained();

    // writes to unlisted indexes leave the settings alone
    write_reg(CFG_UNUSED_A, 49'd12345);
    write_reg(CFG_UNUSED_B, '0);
    write_reg(msm_pkg::CFG_MULTIPLIER, ALL_ONES);
    coef_pending.push_back(ALL_ONES);
    coef_pending.push_back(ALL_ONES - 1);
    coef_pending.push_back(1);
    wait_drained();

    // zero modulus gives zero
    write_reg(msm_pkg::CFG_MODULUS, '0);
    coef_pending.push_back(ALL_ONES);
    coef_pending.push_back(7);
    wait_drained();

    // modulus one
    write_reg(msm_pkg::CFG_MODULUS, 1);
    coef_pending.push_back(ALL_ONES);
    coef_pending.push_back(0);
    wait_drained();

    // modulus two, operands above modulus, zero multiplier
    write_reg(msm_pkg::CFG_MODULUS, 2);
    write_reg(msm_pkg::CFG_MULTIPLIER, 3);
    coef_pending.push_back(5);
    coef_pending.push_back(ALL_ONES);
    coef_pending.push_back(4);
    wait_drained();
    write_reg(msm_pkg::CFG_MULTIPLIER, '0);
    coef_pending.push_back(ALL_ONES);
    wait_drained();

    // shift by 48 bits as a multiplier, largest odd modulus below the max
    write_reg(msm_pkg::CFG_MODULUS, ALL_ONES - 2);
    write_reg(msm_pkg::CFG_MULTIPLIER, msm_pkg::W'(1) << (msm_pkg::W - 1));
    coef_pending.push_back(ALL_ONES - 3);
    coef_pending.push_back(ALL_ONES);
    coef_pending.push_back(1);
    wait_drained();

    // random settings; one long stretch runs with no idling on either side
    for (int ph = 0; ph < 14; ph++) begin
      tx_idle_pct = (ph == 5) ? 0 : 29;
      rx_idle_pct = (ph == 5) ? 0 : 29;
      case (ph % 4)
        0: q = rand_word() | 1;
        1: q = msm_pkg::W'($urandom_range(3, 1000)) | 1;
        2: q = ALL_ONES - msm_pkg::W'($urandom_range(0, 100));
        default: q = rand_word() >> $urandom_range(0, msm_pkg::W - 2);
      endcase
      write_reg(msm_pkg::CFG_MODULUS, q);
      write_reg(msm_pkg::CFG_MULTIPLIER, ($urandom_range(0, 4) == 0) ? rand_word()
                                         : (q == '0 ? '0 : rand_word() % q));
      // long receiver hold-off with more items than the pipe can hold
      if (ph == 2) begin
        hold_req = 1'b1;
        push_random(160);
      end else begin
        push_random(105);
      end
      wait_drained();
    end

    repeat (250) @(posedge clk);
    if (n_errors == 0 && product_expected.size() == 0)
      $display("tb_top: done, clean");
    else begin
      if (product_expected.size() != 0)
        $error("%0d expected products never arrived", product_expected.size());
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/msm_pkg.sv
hw/rtl/msm_if.sv
hw/rtl/msm_reduce_stage.sv
hw/rtl/msm_mul_stage.sv
hw/rtl/modular_scalar_multiply_core.sv
sim/tb_top.sv
